>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qwfp: same-cycle check failed");

// next-cycle implication
`define QW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qwfp: next-cycle check failed");

`endif

>>> sv/qwfp_pkg.sv
// ----------------------------------------------------------------------------
// qwfp_pkg
// types, codes and constants of the queue watermark flow / pong block
// ----------------------------------------------------------------------------
package qwfp_pkg;

	// field widths
	localparam int CNT_W      = 10;
	localparam int LIM_W      = 10;
	localparam int PCT_W      = 7;
	localparam int DAMP_W     = 10;
	localparam int DEPTH_W    = 11;
	localparam int MARK_W     = 12;
	localparam int LVL_W      = 2;
	localparam int PROD_W     = LIM_W + PCT_W;
	localparam int QUOT_W     = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int BUSY_W     = 2;

	// parameter defaults
	localparam int QUEUE_CAP_DEF  = 1023;
	localparam int MIN_WINDOW_DEF = 1;
	localparam int MIN_DEPTH_DEF  = 1;

	// divide by 100 as multiply by ceil(2^24 / 100), exact for products below 2^17
	localparam int DIV100_SHIFT = 24;
	localparam int RECIP_W      = 18;
	localparam logic [RECIP_W-1:0] DIV100_MUL = 18'd167773;
	localparam int WIDE_W       = PROD_W + RECIP_W;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK_PCT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK_PCT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_BAND     = 3'd3;

	// register reset values
	localparam logic [LIM_W-1:0]  QUEUE_LIMIT_RST   = 10'd1023;
	localparam logic [PCT_W-1:0]  LOW_MARK_PCT_RST  = 7'd25;
	localparam logic [PCT_W-1:0]  HIGH_MARK_PCT_RST = 7'd75;
	localparam logic [DAMP_W-1:0] DAMP_BAND_RST     = 10'd0;

	// request kinds
	localparam logic REQ_CHECK = 1'b0;
	localparam logic REQ_PONG  = 1'b1;

	// congestion levels
	localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
	localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd1;
	localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_FULL   = 2'd3;

	// flow indication codes
	localparam logic [LVL_W-1:0] FLOW_LOW    = 2'd0;
	localparam logic [LVL_W-1:0] FLOW_NORMAL = 2'd1;
	localparam logic [LVL_W-1:0] FLOW_FULL   = 2'd2;
	localparam logic [LVL_W-1:0] FLOW_HIGH   = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [CNT_W-1:0]  queue_count;
		logic              peer_open;
	} in_word_t;

	typedef struct packed {
		logic               flow_valid;
		logic [LVL_W-1:0]   flow_code;
		logic               flow_rising;
		logic               pong_valid;
		logic [DEPTH_W-1:0] pong_window;
		logic [LVL_W-1:0]   queue_level;
	} out_word_t;

	// derived watermarks
	typedef struct packed {
		logic [LIM_W-1:0]  lim;
		logic [MARK_W-1:0] low_lo;
		logic [MARK_W-1:0] low_hi;
		logic [MARK_W-1:0] high_lo;
		logic [MARK_W-1:0] high_hi;
	} marks_t;

	// derivation control toward the datapath
	typedef struct packed {
		logic               busy;
		logic               reload;
		logic [DEPTH_W-1:0] reload_depth;
	} mark_ctl_t;

	// datapath state visible to the top level
	typedef struct packed {
		logic             pong_wait;
		logic [LVL_W-1:0] cur_level;
	} core_stat_t;

	function automatic logic [LVL_W-1:0] flow_of(input logic [LVL_W-1:0] lvl);
		logic [LVL_W-1:0] code;
		case (lvl)
			LVL_LOW:    code = FLOW_LOW;
			LVL_NORMAL: code = FLOW_NORMAL;
			LVL_HIGH:   code = FLOW_HIGH;
			default:    code = FLOW_FULL;
		endcase
		return code;
	endfunction

endpackage

>>> sv/qwfp_marks.sv
// ----------------------------------------------------------------------------
// qwfp_marks
// configuration registers and three-stage watermark derivation
// ----------------------------------------------------------------------------
module qwfp_marks #(
	parameter int QUEUE_CAP = qwfp_pkg::QUEUE_CAP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [qwfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qwfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output qwfp_pkg::marks_t                 marks,
	output qwfp_pkg::mark_ctl_t              ctl
);

	localparam int CAP_W = 17;

	logic [qwfp_pkg::LIM_W-1:0]  queue_limit_q;
	logic [qwfp_pkg::PCT_W-1:0]  low_pct_q;
	logic [qwfp_pkg::PCT_W-1:0]  high_pct_q;
	logic [qwfp_pkg::DAMP_W-1:0] damp_q;
	logic [qwfp_pkg::BUSY_W-1:0] busy_q;
	logic                        wr_hit;

	logic [qwfp_pkg::LIM_W-1:0]  lim_c;
	logic [qwfp_pkg::LIM_W-1:0]  lim_s1, lim_s2;
	logic [qwfp_pkg::PROD_W-1:0] prod_low_s1, prod_high_s1;
	logic [qwfp_pkg::DAMP_W-1:0] damp_s1, damp_s2;
	logic [qwfp_pkg::QUOT_W-1:0] q_low_s2, q_high_s2;
	logic [qwfp_pkg::WIDE_W-1:0] wide_low, wide_high;

	logic [qwfp_pkg::MARK_W-1:0] low_w, high_w, damp_w, lim_w, low_sum, high_sum;

	always_comb begin
		wr_hit = 1'b0;
		unique case (cfg_index)
			qwfp_pkg::REG_QUEUE_LIMIT,
			qwfp_pkg::REG_LOW_MARK_PCT,
			qwfp_pkg::REG_HIGH_MARK_PCT,
			qwfp_pkg::REG_DAMP_BAND: wr_hit = cfg_valid;
			default:                 wr_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= qwfp_pkg::QUEUE_LIMIT_RST;
			low_pct_q     <= qwfp_pkg::LOW_MARK_PCT_RST;
			high_pct_q    <= qwfp_pkg::HIGH_MARK_PCT_RST;
			damp_q        <= qwfp_pkg::DAMP_BAND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qwfp_pkg::REG_QUEUE_LIMIT:   queue_limit_q <= cfg_data[qwfp_pkg::LIM_W-1:0];
				qwfp_pkg::REG_LOW_MARK_PCT:  low_pct_q     <= cfg_data[qwfp_pkg::PCT_W-1:0];
				qwfp_pkg::REG_HIGH_MARK_PCT: high_pct_q    <= cfg_data[qwfp_pkg::PCT_W-1:0];
				qwfp_pkg::REG_DAMP_BAND:     damp_q        <= cfg_data[qwfp_pkg::DAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// derivation runs after reset and after each write to a listed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= {qwfp_pkg::BUSY_W{1'b1}};
		end else if (wr_hit) begin
			busy_q <= {qwfp_pkg::BUSY_W{1'b1}};
		end else if (busy_q != '0) begin
			busy_q <= busy_q - 1'b1;
		end
	end

	// effective limit, capped by the build-time capacity
	assign lim_c = ({{(CAP_W-qwfp_pkg::LIM_W){1'b0}}, queue_limit_q} < CAP_W'(QUEUE_CAP))
		? queue_limit_q : qwfp_pkg::LIM_W'(QUEUE_CAP);

	always_ff @(posedge clk) begin
		lim_s1       <= lim_c;
		damp_s1      <= damp_q;
		prod_low_s1  <= qwfp_pkg::PROD_W'(lim_c) * qwfp_pkg::PROD_W'(low_pct_q);
		prod_high_s1 <= qwfp_pkg::PROD_W'(lim_c) * qwfp_pkg::PROD_W'(high_pct_q);
	end

	// percent scaling: product / 100 by reciprocal
	assign wide_low  = qwfp_pkg::WIDE_W'(prod_low_s1)  * qwfp_pkg::WIDE_W'(qwfp_pkg::DIV100_MUL);
	assign wide_high = qwfp_pkg::WIDE_W'(prod_high_s1) * qwfp_pkg::WIDE_W'(qwfp_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		lim_s2    <= lim_s1;
		damp_s2   <= damp_s1;
		q_low_s2  <= wide_low[qwfp_pkg::DIV100_SHIFT +: qwfp_pkg::QUOT_W];
		q_high_s2 <= wide_high[qwfp_pkg::DIV100_SHIFT +: qwfp_pkg::QUOT_W];
	end

	assign low_w    = qwfp_pkg::MARK_W'(q_low_s2);
	assign high_w   = qwfp_pkg::MARK_W'(q_high_s2);
	assign damp_w   = qwfp_pkg::MARK_W'(damp_s2);
	assign lim_w    = qwfp_pkg::MARK_W'(lim_s2);
	assign low_sum  = low_w + damp_w;
	assign high_sum = high_w + damp_w;

	always_ff @(posedge clk) begin
		marks.lim     <= lim_s2;
		marks.low_lo  <= (low_w > (damp_w << 1)) ? (low_w - damp_w) : low_w;
		marks.low_hi  <= low_sum;
		marks.high_lo <= (high_w > damp_w) ? (high_w - damp_w) : '0;
		marks.high_hi <= (high_sum > lim_w) ? high_w : high_sum;
	end

	// low mark never exceeds the depth ceiling, so it loads unclamped
	assign ctl.busy         = (busy_q != '0);
	assign ctl.reload       = (busy_q == qwfp_pkg::BUSY_W'(1));
	assign ctl.reload_depth = q_low_s2;

endmodule

>>> sv/qwfp_core.sv
// ----------------------------------------------------------------------------
// qwfp_core
// level decision, flow report and pong pacing, one word per cycle on fire
// ----------------------------------------------------------------------------
module qwfp_core #(
	parameter int MIN_WINDOW = qwfp_pkg::MIN_WINDOW_DEF,
	parameter int MIN_DEPTH  = qwfp_pkg::MIN_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  qwfp_pkg::in_word_t   item,
	input  qwfp_pkg::marks_t     marks,
	input  qwfp_pkg::mark_ctl_t  ctl,
	output qwfp_pkg::out_word_t  result,
	output qwfp_pkg::core_stat_t stat
);

	logic [qwfp_pkg::LVL_W-1:0]   cur_q, prev_q, new_lvl, next_cur;
	logic                         wait_q, wait_in, next_wait;
	logic [qwfp_pkg::DEPTH_W-1:0] depth_q, next_depth;
	logic [qwfp_pkg::MARK_W-1:0]  cnt_w, window;
	logic                         is_pong, lvl_chk, serve, change, grant;

	always_comb begin
		cnt_w = qwfp_pkg::MARK_W'(item.queue_count);
		if (item.queue_count == '0) begin
			new_lvl = qwfp_pkg::LVL_LOW;
		end else if (cnt_w < marks.low_lo) begin
			new_lvl = qwfp_pkg::LVL_LOW;
		end else if (cnt_w < marks.low_hi) begin
			new_lvl = cur_q;
		end else if (cnt_w < marks.high_lo) begin
			new_lvl = qwfp_pkg::LVL_NORMAL;
		end else if (cnt_w < marks.high_hi) begin
			new_lvl = cur_q;
		end else if (item.queue_count < marks.lim) begin
			new_lvl = qwfp_pkg::LVL_HIGH;
		end else begin
			new_lvl = qwfp_pkg::LVL_FULL;
		end
	end

	always_comb begin
		is_pong  = (item.req_type == qwfp_pkg::REQ_PONG);
		lvl_chk  = !is_pong && item.peer_open;
		serve    = is_pong || item.peer_open;
		change   = lvl_chk && (new_lvl != cur_q);
		next_cur = change ? new_lvl : cur_q;

		wait_in = wait_q || is_pong;
		window  = qwfp_pkg::MARK_W'(depth_q) - cnt_w;
		grant   = serve && wait_in
			&& ($signed(window) >= $signed(qwfp_pkg::MARK_W'(MIN_WINDOW)));

		next_wait  = grant ? 1'b0 : wait_in;
		next_depth = depth_q;
		if (grant) begin
			if (item.queue_count == '0) begin
				if ((qwfp_pkg::MARK_W'(depth_q) < marks.low_hi)
						&& (depth_q < qwfp_pkg::DEPTH_MAX)) begin
					next_depth = depth_q + 1'b1;
				end
			end else if (depth_q > qwfp_pkg::DEPTH_W'(MIN_DEPTH)) begin
				next_depth = depth_q - 1'b1;
			end
		end

		result.flow_valid  = change;
		result.flow_code   = change ? qwfp_pkg::flow_of(new_lvl) : qwfp_pkg::FLOW_LOW;
		result.flow_rising = change && (new_lvl > prev_q);
		result.pong_valid  = grant;
		result.pong_window = grant ? window[qwfp_pkg::DEPTH_W-1:0] : '0;
		result.queue_level = next_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= qwfp_pkg::LVL_LOW;
			prev_q <= qwfp_pkg::LVL_LOW;
			wait_q <= 1'b0;
		end else if (fire) begin
			cur_q  <= next_cur;
			prev_q <= next_cur;
			wait_q <= next_wait;
		end
	end

	// depth is loaded from the low mark once derivation settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.reload) begin
			depth_q <= ctl.reload_depth;
		end else if (fire) begin
			depth_q <= next_depth;
		end
	end

	assign stat.pong_wait = wait_q;
	assign stat.cur_level = cur_q;

endmodule

>>> sv/queue_watermark_flow_pong.sv
// ----------------------------------------------------------------------------
// queue_watermark_flow_pong
// output-queue watermark flow control with hysteresis and pong pacing
// ----------------------------------------------------------------------------
// Takes one input word per cycle unless stalled: each word is a queue level
// check or a pong request and carries the current queue depth. Every
// accepted word gives one result word through the input register, decision
// logic and result register, and back-to-back words are taken at full rate,
// one per cycle, while the result register is free or drains; if it holds,
// input stalls once the input register is full. The rate is set by the level
// and pong depth update between the two registers. The watermarks are
// derived from the configuration registers in a three-stage pipeline
// (limit times percent, divide by 100, damping bands); after reset and after
// every write to a listed register, in_ready stays low while that pipeline
// settles and the pong depth reloads from the new low mark. Configuration
// writes are always taken; writes to an unlisted index are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module queue_watermark_flow_pong #(
	parameter int QUEUE_CAP  = qwfp_pkg::QUEUE_CAP_DEF,
	parameter int MIN_WINDOW = qwfp_pkg::MIN_WINDOW_DEF,
	parameter int MIN_DEPTH  = qwfp_pkg::MIN_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input words
	input  logic                             in_valid,
	output logic                             in_ready,
	input  qwfp_pkg::in_word_t               in_data,
	// result words
	output logic                             out_valid,
	input  logic                             out_ready,
	output qwfp_pkg::out_word_t              out_data,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qwfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qwfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	qwfp_pkg::marks_t     marks;
	qwfp_pkg::mark_ctl_t  ctl;
	qwfp_pkg::core_stat_t stat;
	qwfp_pkg::out_word_t  res_c;
	qwfp_pkg::in_word_t   in_s1;
	qwfp_pkg::out_word_t  out_q;
	logic                 valid_s1;
	logic                 out_valid_q;
	logic                 advance;
	logic                 fire;
	logic                 in_take;

	// register writes need no backpressure
	assign cfg_ready = 1'b1;

	qwfp_marks #(
		.QUEUE_CAP(QUEUE_CAP)
	) u_marks (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.marks    (marks),
		.ctl      (ctl)
	);

	// stage 1 moves into the result register when that register is free or draining
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !ctl.busy && (!valid_s1 || advance);
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1 <= in_data;
		end
	end

	// decision logic and state between input and result registers
	qwfp_core #(
		.MIN_WINDOW(MIN_WINDOW),
		.MIN_DEPTH (MIN_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (in_s1),
		.marks (marks),
		.ctl   (ctl),
		.result(res_c),
		.stat  (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// no flow code or rising flag without a flow indication
	`QW_ASSERT_IMP(a_flow_clean, out_valid && !out_data.flow_valid, (out_data.flow_code == qwfp_pkg::FLOW_LOW) && !out_data.flow_rising)
	// a granted pong clears the pending request
	`QW_ASSERT_NEXT(a_pong_clears, fire && res_c.pong_valid, !stat.pong_wait)
	// the level only moves when a flow indication is reported
	`QW_ASSERT_NEXT(a_level_hold, fire && !res_c.flow_valid, $stable(stat.cur_level))
	// a listed register write stalls input while the marks settle
	`QW_ASSERT_NEXT(a_cfg_stall, cfg_valid && cfg_ready && (cfg_index <= qwfp_pkg::REG_DAMP_BAND), !in_ready)

endmodule

>>> test/queue_watermark_flow_pong_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queue_watermark_flow_pong_tb
// self-checking bench: a directed table, then random words under several
// watermark setups; each result word held to a pinned row or the predictor
// ----------------------------------------------------------------------------
module queue_watermark_flow_pong_tb;

	// block parameters, also used by the predictor
	localparam int CAP       = qwfp_pkg::QUEUE_CAP_DEF;
	localparam int WIN_MIN   = qwfp_pkg::MIN_WINDOW_DEF;
	localparam int DEPTH_MIN = qwfp_pkg::MIN_DEPTH_DEF;

	localparam int PCT_FULL    = 100;
	localparam int CNT_MAX     = (1 << qwfp_pkg::CNT_W) - 1;
	localparam int DEPTH_CAP   = (1 << qwfp_pkg::DEPTH_W) - 1;
	localparam int HALF_PERIOD = 5;

	// pressure, watchdog and drain tail
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 12;
	localparam int SHOW_MAX    = 10;

	// random part: general phases and one long pong-depth climb
	localparam int PHASES     = 6;
	localparam int CLIMB_PH   = 2;
	localparam int PHASE_LEN  = 80;
	localparam int CLIMB_LEN  = 820;
	localparam int CLIMB_TAIL = 40;
	localparam int CLIMB_MIX  = 25;

	// an index outside the register list
	localparam logic [qwfp_pkg::CFG_IDX_W-1:0] REG_UNLISTED = 3'd5;

	// ------------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------------
	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	qwfp_pkg::in_word_t              in_data;
	logic                            out_valid;
	logic                            out_ready;
	qwfp_pkg::out_word_t             out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [qwfp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [qwfp_pkg::CFG_DATA_W-1:0] cfg_data;

	queue_watermark_flow_pong #(
		.QUEUE_CAP (CAP),
		.MIN_WINDOW(WIN_MIN),
		.MIN_DEPTH (DEPTH_MIN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor state: register copies, derived marks, level and pong state
	// ------------------------------------------------------------------------
	int lim_reg, low_pct_reg, high_pct_reg, damp_reg;
	int m_lim, m_low, m_low_lo, m_low_hi, m_high_lo, m_high_hi;

	logic [qwfp_pkg::LVL_W-1:0] lvl_now;
	logic [qwfp_pkg::LVL_W-1:0] lvl_last;
	logic                       pong_pending;
	int                         depth_now;
	int                         depth_peak;

	// result words still owed by the block, oldest first
	qwfp_pkg::out_word_t due_reports[$];

	// run bookkeeping
	int words_sent, directed_words, reports_seen, cfg_writes, setups;
	int flows_seen, grants_seen, mismatches;
	int send_gap, take_gap;
	int hold_left;
	bit held;
	int dead_cycles;

	// marks follow every write to a listed register, pong depth reloads too
	function automatic void recompute_marks();
		int hi;
		m_lim     = (lim_reg < CAP) ? lim_reg : CAP;
		m_low     = m_lim * low_pct_reg / PCT_FULL;
		hi        = m_lim * high_pct_reg / PCT_FULL;
		m_low_lo  = (m_low > 2 * damp_reg) ? m_low - damp_reg : m_low;
		m_low_hi  = m_low + damp_reg;
		m_high_lo = (hi > damp_reg) ? hi - damp_reg : 0;
		m_high_hi = (hi + damp_reg > m_lim) ? hi : hi + damp_reg;
		depth_now = (m_low > DEPTH_CAP) ? DEPTH_CAP : m_low;
	endfunction

	function automatic void take_setting(input logic [qwfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [qwfp_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			qwfp_pkg::REG_QUEUE_LIMIT:   lim_reg      = int'(val[qwfp_pkg::LIM_W-1:0]);
			qwfp_pkg::REG_LOW_MARK_PCT:  low_pct_reg  = int'(val[qwfp_pkg::PCT_W-1:0]);
			qwfp_pkg::REG_HIGH_MARK_PCT: high_pct_reg = int'(val[qwfp_pkg::PCT_W-1:0]);
			qwfp_pkg::REG_DAMP_BAND:     damp_reg     = int'(val[qwfp_pkg::DAMP_W-1:0]);
			default:                     return;
		endcase
		recompute_marks();
	endfunction

	// inside a band the level holds
	function automatic logic [qwfp_pkg::LVL_W-1:0] level_of(input int c);
		if (c == 0) return qwfp_pkg::LVL_LOW;
		if (c < m_low_lo) return qwfp_pkg::LVL_LOW;
		if (c < m_low_hi) return lvl_now;
		if (c < m_high_lo) return qwfp_pkg::LVL_NORMAL;
		if (c < m_high_hi) return lvl_now;
		if (c < m_lim) return qwfp_pkg::LVL_HIGH;
		return qwfp_pkg::LVL_FULL;
	endfunction

	// grant a waiting pong when the window is open, then nudge the depth
	function automatic void pong_turn(input int c, inout qwfp_pkg::out_word_t r);
		int win;
		win = depth_now - c;
		if (pong_pending && win >= WIN_MIN) begin
			pong_pending = 1'b0;
			if (c == 0) begin
				if (depth_now < m_low_hi && depth_now < DEPTH_CAP)
					depth_now++;
			end else if (depth_now > DEPTH_MIN) begin
				depth_now--;
			end
			r.pong_valid  = 1'b1;
			r.pong_window = win[qwfp_pkg::DEPTH_W-1:0];
			if (depth_now > depth_peak)
				depth_peak = depth_now;
		end
	endfunction

	function automatic qwfp_pkg::out_word_t forecast_report(input qwfp_pkg::in_word_t w);
		qwfp_pkg::out_word_t        r;
		logic [qwfp_pkg::LVL_W-1:0] nl;
		r = '0;
		if (w.req_type == qwfp_pkg::REQ_PONG) begin
			// peer_open plays no part for a pong request
			pong_pending = 1'b1;
			pong_turn(int'(w.queue_count), r);
		end else if (w.peer_open) begin
			nl = level_of(int'(w.queue_count));
			if (nl != lvl_now) begin
				r.flow_valid  = 1'b1;
				r.flow_rising = (nl > lvl_last);
				case (nl)
					qwfp_pkg::LVL_LOW:    r.flow_code = qwfp_pkg::FLOW_LOW;
					qwfp_pkg::LVL_NORMAL: r.flow_code = qwfp_pkg::FLOW_NORMAL;
					qwfp_pkg::LVL_HIGH:   r.flow_code = qwfp_pkg::FLOW_HIGH;
					default:              r.flow_code = qwfp_pkg::FLOW_FULL;
				endcase
				lvl_now  = nl;
				lvl_last = nl;
			end
			pong_turn(int'(w.queue_count), r);
		end
		// a level check toward a closed peer leaves everything alone
		r.queue_level = lvl_now;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------------
	typedef struct packed {
		bit                              is_cfg;
		logic [qwfp_pkg::CFG_IDX_W-1:0]  idx;
		logic [qwfp_pkg::CFG_DATA_W-1:0] val;
		qwfp_pkg::in_word_t              w;
		bit                              pinned;
		qwfp_pkg::out_word_t             want;
	} step_t;

	function automatic qwfp_pkg::out_word_t quiet(input logic [qwfp_pkg::LVL_W-1:0] lvl);
		qwfp_pkg::out_word_t r;
		r = '0;
		r.queue_level = lvl;
		return r;
	endfunction

	function automatic step_t cfg_row(input logic [qwfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [qwfp_pkg::CFG_DATA_W-1:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.val    = val;
		return s;
	endfunction

	function automatic step_t ask_row(input logic req,
			input logic [qwfp_pkg::CNT_W-1:0] cnt, input logic peer);
		step_t s;
		s = '0;
		s.w = qwfp_pkg::in_word_t'{req, cnt, peer};
		return s;
	endfunction

	function automatic step_t pin_row(input logic req,
			input logic [qwfp_pkg::CNT_W-1:0] cnt, input logic peer,
			input qwfp_pkg::out_word_t want);
		step_t s;
		s = ask_row(req, cnt, peer);
		s.pinned = 1'b1;
		s.want   = want;
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// random word shaping
	// ------------------------------------------------------------------------

	// counts cluster on the marks, the limit and the pong depth
	function automatic logic [qwfp_pkg::CNT_W-1:0] near_count();
		int v;
		case ($urandom_range(9))
			0:       v = 0;
			1:       v = CNT_MAX;
			2:       v = m_lim + int'($urandom_range(2)) - 1;
			3:       v = m_low_lo + int'($urandom_range(4)) - 2;
			4:       v = m_low_hi + int'($urandom_range(4)) - 2;
			5:       v = m_high_lo + int'($urandom_range(4)) - 2;
			6:       v = m_high_hi + int'($urandom_range(4)) - 2;
			7:       v = depth_now + int'($urandom_range(2)) - 1;
			default: v = int'($urandom_range(CNT_MAX));
		endcase
		if (v < 0)
			v = 0;
		else if (v > CNT_MAX)
			v = CNT_MAX;
		return qwfp_pkg::CNT_W'(v);
	endfunction

	// mostly level checks toward an open peer, some pongs, some closed-peer noise
	function automatic qwfp_pkg::in_word_t random_word();
		qwfp_pkg::in_word_t w;
		int                 pick;
		pick = int'($urandom_range(99));
		if (pick < 18) begin
			w.req_type    = qwfp_pkg::REQ_PONG;
			w.queue_count = near_count();
			w.peer_open   = 1'($urandom);
		end else if (pick < 28) begin
			w.req_type    = qwfp_pkg::REQ_CHECK;
			w.queue_count = qwfp_pkg::CNT_W'($urandom);
			w.peer_open   = 1'b0;
		end else begin
			w.req_type    = qwfp_pkg::REQ_CHECK;
			w.queue_count = near_count();
			w.peer_open   = 1'b1;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one word, optionally after a gap; valid is left high after the
	// handshake so back-to-back words keep it up
	task automatic push_word(input qwfp_pkg::in_word_t w, input bit pinned,
			input qwfp_pkg::out_word_t pinned_val);
		qwfp_pkg::out_word_t r;
		if ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = forecast_report(w);
		due_reports.push_back(pinned ? pinned_val : r);
		words_sent++;
	endtask

	// valid stays high across a run of writes; the caller lowers it
	task automatic write_reg(input logic [qwfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [qwfp_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		take_setting(idx, val);
		cfg_writes++;
	endtask

	// stop offering and wait until every owed word has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	function automatic string show(input qwfp_pkg::out_word_t r);
		return $sformatf("flow v%0d c%0d r%0d pong v%0d w%0d level %0d",
			r.flow_valid, r.flow_code, r.flow_rising, r.pong_valid,
			r.pong_window, r.queue_level);
	endfunction

	task automatic flag_mismatch(input string what, input qwfp_pkg::out_word_t want,
			input qwfp_pkg::out_word_t got);
		if (mismatches < SHOW_MAX)
			$display("mismatch @%0t result %0d: %s | due %s | got %s",
				$time, reports_seen, what, show(want), show(got));
		mismatches++;
	endtask

	task automatic check_report(input qwfp_pkg::out_word_t got);
		qwfp_pkg::out_word_t want;
		reports_seen++;
		if (got.flow_valid)
			flows_seen++;
		if (got.pong_valid)
			grants_seen++;
		if (due_reports.size() == 0) begin
			flag_mismatch("word with nothing due", '0, got);
		end else begin
			want = due_reports.pop_front();
			if (got.flow_valid !== want.flow_valid || got.flow_code !== want.flow_code ||
					got.flow_rising !== want.flow_rising ||
					got.pong_valid !== want.pong_valid ||
					got.pong_window !== want.pong_window ||
					got.queue_level !== want.queue_level)
				flag_mismatch("field differs", want, got);
		end
	endtask

	// receiver: random backpressure, plus one long hold once enough results
	// have come, so the pipeline fills and in_ready drops
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_report(out_data);
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else if (!held && reports_seen >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= take_gap);
			end
		end
	end

	// watchdog: cycles in which no word, result or write moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			dead_cycles <= 0;
		end else if (dead_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		step_t                           plan[$];
		logic [qwfp_pkg::CFG_DATA_W-1:0] lim_v;
		logic [qwfp_pkg::PCT_W-1:0]      lo_v, hi_v, swap_v;
		logic [qwfp_pkg::CFG_DATA_W-1:0] damp_v;
		int                              phase, k, len;
		int                              rand_words;
		qwfp_pkg::in_word_t              w;

		// everything known from time zero, reset held low
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		hold_left  = 0;
		held       = 1'b0;
		dead_cycles = 0;
		rand_words = 0;

		// predictor at its reset point
		lim_reg      = int'(qwfp_pkg::QUEUE_LIMIT_RST);
		low_pct_reg  = int'(qwfp_pkg::LOW_MARK_PCT_RST);
		high_pct_reg = int'(qwfp_pkg::HIGH_MARK_PCT_RST);
		damp_reg     = int'(qwfp_pkg::DAMP_BAND_RST);
		lvl_now      = qwfp_pkg::LVL_LOW;
		lvl_last     = qwfp_pkg::LVL_LOW;
		pong_pending = 1'b0;
		recompute_marks();
		depth_peak   = depth_now;

		// sender idles 32 percent, receiver 68 percent
		send_gap = 32;
		take_gap = 68;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk; marks after reset are low 255, high 767, no damping
		plan = '{
			// empty queue and a closed peer leave the low level alone
			pin_row(qwfp_pkg::REQ_CHECK, 0, 1'b1, quiet(qwfp_pkg::LVL_LOW)),
			pin_row(qwfp_pkg::REQ_CHECK, 1023, 1'b0, quiet(qwfp_pkg::LVL_LOW)),
			// full queue jumps straight to full
			pin_row(qwfp_pkg::REQ_CHECK, 1023, 1'b1,
				qwfp_pkg::out_word_t'{1'b1, qwfp_pkg::FLOW_FULL, 1'b1, 1'b0, 11'd0,
					qwfp_pkg::LVL_FULL}),
			// pong with no peer is still served; 255 is the reset low mark
			pin_row(qwfp_pkg::REQ_PONG, 0, 1'b0,
				qwfp_pkg::out_word_t'{1'b0, 2'd0, 1'b0, 1'b1, 11'd255,
					qwfp_pkg::LVL_FULL}),
			pin_row(qwfp_pkg::REQ_CHECK, 0, 1'b1,
				qwfp_pkg::out_word_t'{1'b1, qwfp_pkg::FLOW_LOW, 1'b0, 1'b0, 11'd0,
					qwfp_pkg::LVL_LOW}),
			// window negative, pong stays pending
			pin_row(qwfp_pkg::REQ_PONG, 1023, 1'b1, quiet(qwfp_pkg::LVL_LOW)),
			ask_row(qwfp_pkg::REQ_CHECK, 500, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 800, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 10, 1'b1),
			ask_row(qwfp_pkg::REQ_PONG, 0, 1'b0),
			ask_row(qwfp_pkg::REQ_PONG, 300, 1'b1),
			// damping bands around both marks
			cfg_row(qwfp_pkg::REG_DAMP_BAND, 100),
			ask_row(qwfp_pkg::REQ_CHECK, 300, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 400, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 700, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 870, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 100, 1'b1),
			// zero limit: any nonzero count is full
			cfg_row(qwfp_pkg::REG_DAMP_BAND, 0),
			cfg_row(qwfp_pkg::REG_QUEUE_LIMIT, 0),
			ask_row(qwfp_pkg::REQ_CHECK, 1, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 0, 1'b1),
			ask_row(qwfp_pkg::REQ_PONG, 0, 1'b1),
			// write to an index off the list is dropped
			cfg_row(REG_UNLISTED, 1023),
			// percent above 100 and widest damping
			cfg_row(qwfp_pkg::REG_QUEUE_LIMIT, 1023),
			cfg_row(qwfp_pkg::REG_LOW_MARK_PCT, 100),
			cfg_row(qwfp_pkg::REG_HIGH_MARK_PCT, 127),
			cfg_row(qwfp_pkg::REG_DAMP_BAND, 1023),
			ask_row(qwfp_pkg::REQ_CHECK, 1023, 1'b1),
			ask_row(qwfp_pkg::REQ_PONG, 0, 1'b0),
			ask_row(qwfp_pkg::REQ_CHECK, 600, 1'b1),
			// zero percent marks
			cfg_row(qwfp_pkg::REG_LOW_MARK_PCT, 0),
			cfg_row(qwfp_pkg::REG_HIGH_MARK_PCT, 0),
			ask_row(qwfp_pkg::REQ_CHECK, 1023, 1'b1),
			ask_row(qwfp_pkg::REQ_CHECK, 512, 1'b1),
			ask_row(qwfp_pkg::REQ_PONG, 0, 1'b1)
		};

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				if (cfg_valid)
					cfg_valid <= 1'b0;
				push_word(plan[i].w, plan[i].pinned, plan[i].want);
			end
		end
		directed_words = words_sent;

		// random phases, each under a fresh setup written while idle
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase == CLIMB_PH) begin
				// largest low mark and band, so the depth can climb to its ceiling
				write_reg(qwfp_pkg::REG_QUEUE_LIMIT, 1023);
				write_reg(qwfp_pkg::REG_LOW_MARK_PCT, 127);
				write_reg(qwfp_pkg::REG_HIGH_MARK_PCT,
					qwfp_pkg::CFG_DATA_W'($urandom_range(127)));
				write_reg(qwfp_pkg::REG_DAMP_BAND, 1023);
				len = CLIMB_LEN + CLIMB_TAIL;
			end else begin
				case ($urandom_range(5))
					0:       lim_v = 0;
					1:       lim_v = 1;
					2:       lim_v = qwfp_pkg::CFG_DATA_W'(CNT_MAX);
					default: lim_v = qwfp_pkg::CFG_DATA_W'($urandom_range(CNT_MAX, 1));
				endcase
				lo_v = ($urandom_range(9) == 0) ? qwfp_pkg::PCT_W'($urandom_range(127, 101))
					: qwfp_pkg::PCT_W'($urandom_range(PCT_FULL));
				hi_v = ($urandom_range(9) == 0) ? qwfp_pkg::PCT_W'($urandom_range(127, 101))
					: qwfp_pkg::PCT_W'($urandom_range(PCT_FULL));
				// usually keep the low mark under the high one
				if (lo_v > hi_v && $urandom_range(9) < 7) begin
					swap_v = lo_v;
					lo_v   = hi_v;
					hi_v   = swap_v;
				end
				case ($urandom_range(3))
					0:       damp_v = 0;
					1:       damp_v = qwfp_pkg::CFG_DATA_W'($urandom_range(40, 1));
					2:       damp_v = qwfp_pkg::CFG_DATA_W'($urandom_range(200));
					default: damp_v = qwfp_pkg::CFG_DATA_W'($urandom);
				endcase
				// upper data bits above a percent field are don't-care
				write_reg(qwfp_pkg::REG_QUEUE_LIMIT, lim_v);
				write_reg(qwfp_pkg::REG_LOW_MARK_PCT, {3'($urandom), lo_v});
				write_reg(qwfp_pkg::REG_HIGH_MARK_PCT, {3'($urandom), hi_v});
				write_reg(qwfp_pkg::REG_DAMP_BAND, damp_v);
				if ($urandom_range(2) == 0)
					write_reg(qwfp_pkg::CFG_IDX_W'($urandom_range(
						(1 << qwfp_pkg::CFG_IDX_W) - 1,
						int'(qwfp_pkg::REG_DAMP_BAND) + 1)),
						qwfp_pkg::CFG_DATA_W'($urandom));
				len = PHASE_LEN;
			end
			cfg_valid <= 1'b0;
			setups++;

			for (k = 0; k < len; k++) begin
				// idling pattern: sender light, then receiver light, then none
				if (rand_words < 420) begin
					send_gap = 32;
					take_gap = 68;
				end else if (rand_words < 840) begin
					send_gap = 68;
					take_gap = 32;
				end else begin
					send_gap = 0;
					take_gap = 0;
				end
				if (phase == CLIMB_PH && k < CLIMB_LEN) begin
					// empty-queue pongs push the depth up by one per grant
					if (k % CLIMB_MIX == CLIMB_MIX - 1)
						w = qwfp_pkg::in_word_t'{qwfp_pkg::REQ_CHECK,
							qwfp_pkg::CNT_W'($urandom), 1'($urandom)};
					else
						w = qwfp_pkg::in_word_t'{qwfp_pkg::REQ_PONG,
							qwfp_pkg::CNT_W'(0), 1'($urandom)};
				end else begin
					w = random_word();
				end
				push_word(w, 1'b0, '0);
				rand_words++;
			end
		end

		// drain, then idle through the tail to catch any stray result word
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d words, %0d directed, %0d checked, %0d writes, %0d setups",
			words_sent, directed_words, reports_seen, cfg_writes, setups);
		$display("run: %0d flow changes, %0d pong grants, depth peak %0d, %0d mismatches",
			flows_seen, grants_seen, depth_peak, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
